FILE: rtl/core/iirdf1_pkg.sv
`timescale 1ns / 1ps

package iirdf1_pkg;

    localparam int TAPS       = 8;
    localparam int Q_SHIFT    = 13;
    localparam int SAMPLE_W   = 16;
    localparam int COEFF_W    = 16;
    localparam int INDEX_W    = 3;
    localparam int HIST_W     = 19;
    localparam int ACC_W      = 32;
    localparam int PROD_W     = COEFF_W + HIST_W;
    localparam int PTR_W      = $clog2(TAPS);
    localparam int MEM_DEPTH  = 2 * TAPS;
    localparam int ADDR_W     = $clog2(MEM_DEPTH);

    typedef enum logic [1:0] {
        OP_FILTER = 2'd0,
        OP_WR_NUM = 2'd1,
        OP_WR_DEN = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic clear;
        logic issue;
        logic sub;
    } t_mac_ctl;

endpackage

FILE: rtl/core/iirdf1_if.sv
`timescale 1ns / 1ps

interface iirdf1_in_if;
    import iirdf1_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [1:0]                 op;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic [INDEX_W-1:0]         coeff_index;
    logic signed [COEFF_W-1:0]  coeff_value;

    modport source (output valid, output op, output sample_in, output coeff_index,
                     output coeff_value, input ready);
    modport sink (input valid, input op, input sample_in, input coeff_index,
                   input coeff_value, output ready);
endinterface

interface iirdf1_out_if;
    import iirdf1_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink (input valid, input sample_out, output ready);
endinterface

FILE: rtl/core/iirdf1_ram.sv
`timescale 1ns / 1ps

module iirdf1_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [WIDTH-1:0] r_rd_data;
    logic             r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // Entries never written since reset read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

FILE: rtl/core/iirdf1_mac.sv
`timescale 1ns / 1ps

module iirdf1_mac (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  iirdf1_pkg::t_mac_ctl              i_ctl,
    input  logic signed [iirdf1_pkg::COEFF_W-1:0] i_coeff,
    input  logic signed [iirdf1_pkg::HIST_W-1:0]  i_hist,
    output logic [iirdf1_pkg::ACC_W-1:0]      o_acc,
    output logic                              o_busy
);
    import iirdf1_pkg::*;

    logic                     r_v1;
    logic                     r_sub1;
    logic                     r_v2;
    logic                     r_sub2;
    logic [ACC_W-1:0]         r_prod;
    logic [ACC_W-1:0]         r_acc;
    logic signed [PROD_W-1:0] w_prod;

    assign w_prod = i_coeff * i_hist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_ctl.issue;
            r_v2 <= r_v1;
        end
    end

    // The read data arrives in the cycle after issue; the product is
    // registered, then folded into the accumulator modulo 2^32.
    always_ff @(posedge i_clk) begin
        r_sub1 <= i_ctl.sub;
        r_sub2 <= r_sub1;
        r_prod <= w_prod[ACC_W-1:0];
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_sub2 ? (r_acc - r_prod) : (r_acc + r_prod);
        end
    end

    assign o_acc  = r_acc;
    assign o_busy = r_v1 | r_v2;

endmodule

FILE: rtl/core/iirdf1_ctrl.sv
`timescale 1ns / 1ps

module iirdf1_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    iirdf1_in_if.sink                        i_in,
    iirdf1_out_if.source                     o_out,
    input  logic [iirdf1_pkg::ACC_W-1:0]     i_acc,
    input  logic                             i_mac_busy,
    output iirdf1_pkg::t_mac_ctl             o_mac_ctl,
    output logic                             o_coeff_wr_en,
    output logic [iirdf1_pkg::ADDR_W-1:0]    o_coeff_wr_addr,
    output logic [iirdf1_pkg::COEFF_W-1:0]   o_coeff_wr_data,
    output logic [iirdf1_pkg::ADDR_W-1:0]    o_coeff_rd_addr,
    output logic                             o_hist_wr_en,
    output logic [iirdf1_pkg::ADDR_W-1:0]    o_hist_wr_addr,
    output logic [iirdf1_pkg::HIST_W-1:0]    o_hist_wr_data,
    output logic [iirdf1_pkg::ADDR_W-1:0]    o_hist_rd_addr
);
    import iirdf1_pkg::*;

    t_state             r_state, n_state;
    logic [PTR_W-1:0]   r_ptr, n_ptr;
    logic [PTR_W-1:0]   r_k, n_k;
    logic [PTR_W-1:0]   r_back, n_back;
    logic               r_phase, n_phase;
    logic               r_out_valid, n_out_valid;
    logic [SAMPLE_W-1:0] r_out_data, n_out_data;

    logic               w_accept;
    logic               w_filter;
    logic               w_coeff_wr;
    logic               w_last_tap;
    logic               w_out_free;
    logic [PTR_W-1:0]   w_ptr_next;
    logic [PTR_W-1:0]   w_back_dec;
    logic [PTR_W-1:0]   w_ptr_dec;

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_filter   = w_accept && (i_in.op == OP_FILTER);
    assign w_coeff_wr = w_accept && ((i_in.op == OP_WR_NUM) || (i_in.op == OP_WR_DEN))
                        && (int'(i_in.coeff_index) < TAPS);
    assign w_last_tap = (r_k == PTR_W'(TAPS - 1));
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_ptr_next = (r_ptr == PTR_W'(TAPS - 1)) ? '0 : r_ptr + PTR_W'(1);
    assign w_back_dec = (r_back == '0) ? PTR_W'(TAPS - 1) : r_back - PTR_W'(1);
    assign w_ptr_dec  = (r_ptr == '0) ? PTR_W'(TAPS - 1) : r_ptr - PTR_W'(1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_filter) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (r_phase && w_last_tap) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_mac_busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready      = 1'b0;
        o_mac_ctl       = '0;
        n_ptr           = r_ptr;
        n_k             = r_k;
        n_back          = r_back;
        n_phase         = r_phase;
        n_out_valid     = r_out_valid && !o_out.ready;
        n_out_data      = r_out_data;
        o_hist_wr_en    = 1'b0;
        o_hist_wr_addr  = ADDR_W'(w_ptr_next);
        o_hist_wr_data  = HIST_W'(i_in.sample_in);
        unique case (r_state)
            ST_IDLE: begin
                i_in.ready = 1'b1;
                if (w_filter) begin
                    o_mac_ctl.clear = 1'b1;
                    o_hist_wr_en    = 1'b1;
                    n_ptr           = w_ptr_next;
                    n_k             = '0;
                    n_back          = w_ptr_next;
                    n_phase         = 1'b0;
                end
            end
            ST_RUN: begin
                o_mac_ctl.issue = 1'b1;
                o_mac_ctl.sub   = r_phase;
                if (!r_phase && w_last_tap) begin
                    // Feedback taps start at one sample back.
                    n_phase = 1'b1;
                    n_k     = PTR_W'(1);
                    n_back  = w_ptr_dec;
                end else begin
                    n_k    = r_k + PTR_W'(1);
                    n_back = w_back_dec;
                end
            end
            ST_DRAIN: begin
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_out_valid    = 1'b1;
                    n_out_data     = i_acc[Q_SHIFT+SAMPLE_W-1:Q_SHIFT];
                    o_hist_wr_en   = 1'b1;
                    o_hist_wr_addr = ADDR_W'(TAPS) + ADDR_W'(r_ptr);
                    o_hist_wr_data = i_acc[ACC_W-1:Q_SHIFT];
                end
            end
            default: begin
            end
        endcase
    end

    // Samples and feedforward coefficients live in the lower half of each
    // memory, outputs and feedback coefficients in the upper half.
    assign o_coeff_rd_addr = r_phase ? (ADDR_W'(TAPS) + ADDR_W'(r_k)) : ADDR_W'(r_k);
    assign o_hist_rd_addr  = r_phase ? (ADDR_W'(TAPS) + ADDR_W'(r_back)) : ADDR_W'(r_back);
    assign o_coeff_wr_en   = w_coeff_wr;
    assign o_coeff_wr_addr = (i_in.op == OP_WR_DEN)
                             ? (ADDR_W'(TAPS) + ADDR_W'(i_in.coeff_index))
                             : ADDR_W'(i_in.coeff_index);
    assign o_coeff_wr_data = i_in.coeff_value;

    assign o_out.valid      = r_out_valid;
    assign o_out.sample_out = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ptr       <= '0;
            r_k         <= '0;
            r_back      <= '0;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_k         <= n_k;
            r_back      <= n_back;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

endmodule

FILE: rtl/core/iir_direct_form_one_filter.sv
`timescale 1ns / 1ps

// Channel   Modport  Word
// i_in      sink     op, sample_in, coeff_index, coeff_value
// o_out     source   sample_out
//
// A coefficient write or an unused op code is taken while idle and leaves the block idle.
// A sample is handled by one shared multiply-accumulate that walks 2*TAPS-1 taps
// through the single read port of each memory, then drains.
// Reset is synchronous and active low; all history and coefficients read as zero.
// A waiting result holds off only the end of the next sample, not its acceptance.
module iir_direct_form_one_filter (
    input  logic          i_clk,
    input  logic          i_rst_n,
    iirdf1_in_if.sink     i_in,
    iirdf1_out_if.source  o_out
);
    import iirdf1_pkg::*;

    t_mac_ctl            w_mac_ctl;
    logic [ACC_W-1:0]    w_acc;
    logic                w_mac_busy;
    logic                w_coeff_wr_en;
    logic [ADDR_W-1:0]   w_coeff_wr_addr;
    logic [COEFF_W-1:0]  w_coeff_wr_data;
    logic [ADDR_W-1:0]   w_coeff_rd_addr;
    logic [COEFF_W-1:0]  w_coeff_rd_data;
    logic                w_hist_wr_en;
    logic [ADDR_W-1:0]   w_hist_wr_addr;
    logic [HIST_W-1:0]   w_hist_wr_data;
    logic [ADDR_W-1:0]   w_hist_rd_addr;
    logic [HIST_W-1:0]   w_hist_rd_data;

    iirdf1_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in            (i_in),
        .o_out           (o_out),
        .i_acc           (w_acc),
        .i_mac_busy      (w_mac_busy),
        .o_mac_ctl       (w_mac_ctl),
        .o_coeff_wr_en   (w_coeff_wr_en),
        .o_coeff_wr_addr (w_coeff_wr_addr),
        .o_coeff_wr_data (w_coeff_wr_data),
        .o_coeff_rd_addr (w_coeff_rd_addr),
        .o_hist_wr_en    (w_hist_wr_en),
        .o_hist_wr_addr  (w_hist_wr_addr),
        .o_hist_wr_data  (w_hist_wr_data),
        .o_hist_rd_addr  (w_hist_rd_addr)
    );

    iirdf1_ram #(
        .WIDTH (COEFF_W),
        .DEPTH (MEM_DEPTH)
    ) u_coeff_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_coeff_wr_en),
        .i_wr_addr (w_coeff_wr_addr),
        .i_wr_data (w_coeff_wr_data),
        .i_rd_en   (w_mac_ctl.issue),
        .i_rd_addr (w_coeff_rd_addr),
        .o_rd_data (w_coeff_rd_data)
    );

    iirdf1_ram #(
        .WIDTH (HIST_W),
        .DEPTH (MEM_DEPTH)
    ) u_hist_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_hist_wr_en),
        .i_wr_addr (w_hist_wr_addr),
        .i_wr_data (w_hist_wr_data),
        .i_rd_en   (w_mac_ctl.issue),
        .i_rd_addr (w_hist_rd_addr),
        .o_rd_data (w_hist_rd_data)
    );

    iirdf1_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac_ctl),
        .i_coeff (w_coeff_rd_data),
        .i_hist  (w_hist_rd_data),
        .o_acc   (w_acc),
        .o_busy  (w_mac_busy)
    );

endmodule

FILE: tb/iir_direct_form_one_filter_tb.sv
`timescale 1ns / 1ps

module iir_direct_form_one_filter_tb;
    import iirdf1_pkg::*;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam int         IDLE_LIMIT = 2000;
    localparam int         SETTLE     = 4 * TAPS;
    localparam int         RAND_BLKS  = 35;
    localparam int         BLK_WORDS  = 50;

    typedef struct {
        logic [1:0]                op;
        logic signed [SAMPLE_W-1:0] sample;
        logic [INDEX_W-1:0]         index;
        logic signed [COEFF_W-1:0]  coeff;
    } t_word;

    typedef struct {
        t_word                      w;
        bit                         fixed;
        logic signed [SAMPLE_W-1:0] want;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    iirdf1_in_if  samples_ch ();
    iirdf1_out_if results_ch ();

    iir_direct_form_one_filter i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (samples_ch),
        .o_out   (results_ch)
    );

    // Filter state as the block should hold it.
    logic signed [COEFF_W-1:0]  tap_num [TAPS];
    logic signed [COEFF_W-1:0]  tap_den [TAPS];
    logic signed [SAMPLE_W-1:0] x_line  [TAPS];
    logic signed [HIST_W-1:0]   y_line  [TAPS];
    logic [PTR_W-1:0]           line_ptr;

    logic signed [SAMPLE_W-1:0] filtered_q [$];
    t_dir_row                   dir_rows [$];
    int                         n_errors;
    bit                         steady;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input logic signed [SAMPLE_W-1:0] got,
                                   input logic signed [SAMPLE_W-1:0] want);
        if (n_errors < 50)
            $display("%0t mismatch: %s, got %0d want %0d", $time, what, got, want);
        n_errors++;
    endtask

    // Advances the history and returns the low 16 bits of the Q13 result.
    function automatic logic signed [SAMPLE_W-1:0] filter_sample(
        input logic signed [SAMPLE_W-1:0] x);
        logic [ACC_W-1:0]         acc;
        logic signed [ACC_W-1:0]  ff_prod;
        logic signed [PROD_W-1:0] fb_prod;
        logic signed [ACC_W-1:0]  shifted;
        logic [PTR_W-1:0]         slot;
        acc = '0;
        line_ptr = (line_ptr == PTR_W'(TAPS - 1)) ? '0 : line_ptr + PTR_W'(1);
        x_line[line_ptr] = x;
        for (int k = 0; k < TAPS; k++) begin
            slot = PTR_W'((int'(line_ptr) + TAPS - k) % TAPS);
            ff_prod = tap_num[k] * x_line[slot];
            acc = acc + ff_prod;
        end
        for (int k = 1; k < TAPS; k++) begin
            slot = PTR_W'((int'(line_ptr) + TAPS - k) % TAPS);
            fb_prod = tap_den[k] * y_line[slot];
            acc = acc - fb_prod[ACC_W-1:0];
        end
        shifted = $signed(acc) >>> Q_SHIFT;
        y_line[line_ptr] = shifted[HIST_W-1:0];
        return shifted[SAMPLE_W-1:0];
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_word rand_word(input bit tame);
        t_word w;
        int    r;
        r = $urandom_range(0, 99);
        if (r < 66)
            w.op = OP_FILTER;
        else if (r < 80)
            w.op = OP_WR_NUM;
        else if (r < 95)
            w.op = OP_WR_DEN;
        else
            w.op = OP_UNUSED;
        w.sample = SAMPLE_W'($urandom);
        w.index  = INDEX_W'($urandom);
        w.coeff  = COEFF_W'($urandom);
        // Tame blocks keep most values small so the output history is not just wrap noise.
        if (tame && $urandom_range(0, 3) != 0) begin
            w.sample = w.sample >>> 3;
            w.coeff  = w.coeff >>> 4;
        end
        return w;
    endfunction

    function automatic void add_row(input logic [1:0] op, input int sample, input int index,
                                    input int coeff, input bit fixed, input int want);
        t_dir_row row;
        row.w.op     = op;
        row.w.sample = SAMPLE_W'(sample);
        row.w.index  = INDEX_W'(index);
        row.w.coeff  = COEFF_W'(coeff);
        row.fixed    = fixed;
        row.want     = SAMPLE_W'(want);
        dir_rows.push_back(row);
    endfunction

    // Drives one word, waits for it to be taken, then updates the predicted state.
    task automatic push_word(input t_word w, input bit fixed,
                             input logic signed [SAMPLE_W-1:0] want);
        logic signed [SAMPLE_W-1:0] pred;
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            samples_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        samples_ch.valid       <= 1'b1;
        samples_ch.op          <= w.op;
        samples_ch.sample_in   <= w.sample;
        samples_ch.coeff_index <= w.index;
        samples_ch.coeff_value <= w.coeff;
        @(posedge i_clk);
        while (!samples_ch.ready) @(posedge i_clk);

        if (w.op == OP_FILTER) begin
            pred = filter_sample(w.sample);
            filtered_q.push_back(fixed ? want : pred);
        end else if (w.op == OP_WR_NUM && int'(w.index) < TAPS) begin
            tap_num[w.index] = w.coeff;
        end else if (w.op == OP_WR_DEN && int'(w.index) < TAPS) begin
            tap_den[w.index] = w.coeff;
        end
    endtask

    initial begin : stimulus
        bit tame;
        i_rst_n                <= 1'b0;
        samples_ch.valid       <= 1'b0;
        samples_ch.op          <= OP_FILTER;
        samples_ch.sample_in   <= '0;
        samples_ch.coeff_index <= '0;
        samples_ch.coeff_value <= '0;
        n_errors = 0;
        steady   = 1'b0;
        line_ptr = '0;
        for (int k = 0; k < TAPS; k++) begin
            tap_num[k] = '0;
            tap_den[k] = '0;
            x_line[k]  = '0;
            y_line[k]  = '0;
        end

        // All coefficients are zero out of reset, so samples come out as zero.
        add_row(OP_FILTER,  32767, 0,      0, 1, 0);
        add_row(OP_FILTER, -32768, 0,      0, 1, 0);
        add_row(OP_UNUSED,  23130, 7,     -1, 0, 0);
        // A unit gain on the newest sample passes it straight through.
        add_row(OP_WR_NUM,      0, 0,   8192, 0, 0);
        add_row(OP_FILTER,  32767, 0,      0, 1, 32767);
        add_row(OP_FILTER, -32768, 0,      0, 1, -32768);
        add_row(OP_FILTER,     -1, 0,      0, 1, -1);
        // An unused op code must not touch the coefficient at tap zero.
        add_row(OP_UNUSED,      0, 0,      0, 0, 0);
        add_row(OP_FILTER,    100, 0,      0, 1, 100);
        add_row(OP_WR_NUM,      0, 7, -32768, 0, 0);
        // The feedback coefficient at tap zero is stored but never used.
        add_row(OP_WR_DEN,      0, 0,  32767, 0, 0);
        add_row(OP_FILTER,      1, 0,      0, 0, 0);
        add_row(OP_WR_DEN,      0, 1, -32768, 0, 0);
        add_row(OP_WR_DEN,      0, 7,  32767, 0, 0);
        add_row(OP_FILTER,  32767, 0,      0, 0, 0);
        add_row(OP_FILTER, -32768, 0,      0, 0, 0);
        add_row(OP_WR_NUM,      0, 0,  32767, 0, 0);
        add_row(OP_WR_NUM,      0, 3, -32768, 0, 0);
        add_row(OP_FILTER,  32767, 0,      0, 0, 0);
        add_row(OP_FILTER, -32768, 0,      0, 0, 0);
        add_row(OP_FILTER,      0, 0,      0, 0, 0);
        add_row(OP_WR_DEN,      0, 1,      0, 0, 0);
        add_row(OP_WR_DEN,      0, 7,      0, 0, 0);
        add_row(OP_FILTER,  12345, 0,      0, 0, 0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i])
            push_word(dir_rows[i].w, dir_rows[i].fixed, dir_rows[i].want);

        for (int blk = 0; blk < RAND_BLKS; blk++) begin
            steady = ($urandom_range(0, 3) == 0);
            tame   = ($urandom_range(0, 1) == 0);
            for (int j = 0; j < BLK_WORDS; j++)
                push_word(rand_word(tame), 1'b0, '0);
        end
        steady = 1'b0;
        samples_ch.valid <= 1'b0;

        while (filtered_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (n_errors == 0)
            $display("iir_direct_form_one_filter_tb: done, clean");
        else
            $display("iir_direct_form_one_filter_tb: done, errors");
        $finish;
    end

    initial begin : result_side
        int                         stall_left;
        logic signed [SAMPLE_W-1:0] want;
        stall_left = 0;
        results_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n) begin
                if (results_ch.valid && results_ch.ready) begin
                    if (filtered_q.size() == 0) begin
                        report_mismatch("output word with none pending",
                                        results_ch.sample_out, '0);
                    end else begin
                        want = filtered_q.pop_front();
                        if (results_ch.sample_out !== want)
                            report_mismatch("sample_out", results_ch.sample_out, want);
                    end
                end
                if (stall_left > 0) begin
                    results_ch.ready <= 1'b0;
                    stall_left--;
                end else begin
                    results_ch.ready <= 1'b1;
                    stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
                end
            end
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((samples_ch.valid && samples_ch.ready) ||
                (results_ch.valid && results_ch.ready))
                idle = 0;
            else
                idle++;
        end
        $display("iir_direct_form_one_filter_tb: done, errors");
        $finish;
    end

endmodule

FILE: iir_direct_form_one_filter.f
rtl/core/iirdf1_pkg.sv
rtl/core/iirdf1_if.sv
rtl/core/iirdf1_ram.sv
rtl/core/iirdf1_mac.sv
rtl/core/iirdf1_ctrl.sv
rtl/core/iir_direct_form_one_filter.sv
tb/iir_direct_form_one_filter_tb.sv
